// File: design/pss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the credit saturation function for the symbol sequencer.
package pss_pkg;

	localparam int CREDIT_W    = 24;
	localparam int WEIGHT_W    = 16;
	localparam int TOTAL_W     = 18;
	localparam int NUM_WEIGHTS = 4;
	localparam int IDX_W       = 3;
	localparam int SYM_W       = 2;
	localparam int POS_W       = 32;
	localparam int NSYM_W      = 3;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int SAT_W       = CREDIT_W + 3;

	typedef logic signed [CREDIT_W-1:0] credit_t;

	localparam credit_t CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
	localparam credit_t CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SEQ_LEN  = 3'd0,
		REG_SYMBOLS  = 3'd1,
		REG_WEIGHT0  = 3'd2,
		REG_WEIGHT1  = 3'd3,
		REG_WEIGHT2  = 3'd4,
		REG_WEIGHT3  = 3'd5
	} reg_idx_t;

	// Token handed down the cell chain: running best credit and weight total
	typedef struct packed {
		logic                valid;
		credit_t             best;
		logic [IDX_W-1:0]    idx;
		logic [TOTAL_W-1:0]  total;
	} tok_t;

	typedef struct packed {
		logic                clear;
		logic                debit;
		logic [IDX_W-1:0]    winner;
		logic [TOTAL_W-1:0]  total;
	} cell_ctl_t;

	typedef struct packed {
		logic [POS_W-1:0]                      seq_len;
		logic [NSYM_W-1:0]                     n_active;
		logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0]  weight;
	} cfg_t;

	function automatic credit_t sat_credit(input logic signed [SAT_W-1:0] v);
		credit_t r;
		if (v > $signed({{(SAT_W-CREDIT_W){1'b0}}, CREDIT_MAX})) begin
			r = CREDIT_MAX;
		end else if (v < $signed({{(SAT_W-CREDIT_W){1'b1}}, CREDIT_MIN})) begin
			r = CREDIT_MIN;
		end else begin
			r = v[CREDIT_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: design/pss_intf.sv
`timescale 1ns / 1ps
// Channel interfaces: input tick, result and configuration write.
interface pss_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface pss_out_if;
	import pss_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic [POS_W-1:0] position;
	logic             last;

	modport source (output valid, output symbol, output position, output last, input ready);
	modport sink   (input valid, input symbol, input position, input last, output ready);
endinterface

interface pss_cfg_if;
	import pss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: design/pss_cfg.sv
`timescale 1ns / 1ps
// Configuration register file with alphabet size clamping.
module pss_cfg #(
	parameter int unsigned MAX_SYMBOLS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	pss_cfg_if.sink         cfg_ch,
	output pss_pkg::cfg_t   cfg
);
	import pss_pkg::*;

	localparam int LIM = (MAX_SYMBOLS < NUM_WEIGHTS) ? MAX_SYMBOLS : NUM_WEIGHTS;

	logic [POS_W-1:0]                     seq_len_q;
	logic [NSYM_W-1:0]                    symbols_q;
	logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_q;
	logic [NSYM_W-1:0]                    n_active;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q   <= POS_W'(16);
			symbols_q   <= NSYM_W'(2);
			weight_q[0] <= WEIGHT_W'(1);
			weight_q[1] <= WEIGHT_W'(1);
			weight_q[2] <= '0;
			weight_q[3] <= '0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (reg_idx_t'(cfg_ch.addr))
				REG_SEQ_LEN: seq_len_q   <= cfg_ch.data;
				REG_SYMBOLS: symbols_q   <= cfg_ch.data[NSYM_W-1:0];
				REG_WEIGHT0: weight_q[0] <= cfg_ch.data[WEIGHT_W-1:0];
				REG_WEIGHT1: weight_q[1] <= cfg_ch.data[WEIGHT_W-1:0];
				REG_WEIGHT2: weight_q[2] <= cfg_ch.data[WEIGHT_W-1:0];
				REG_WEIGHT3: weight_q[3] <= cfg_ch.data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (symbols_q == '0) begin
			n_active = NSYM_W'(1);
		end else if (symbols_q > NSYM_W'(LIM)) begin
			n_active = NSYM_W'(LIM);
		end else begin
			n_active = symbols_q;
		end
	end

	assign cfg.seq_len  = seq_len_q;
	assign cfg.n_active = n_active;
	assign cfg.weight   = weight_q;

endmodule

// File: design/pss_cell.sv
`timescale 1ns / 1ps
// One symbol cell: holds its credit, grows it when the token passes and competes for best.
module pss_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pss_pkg::cell_ctl_t              ctl,
	input  logic                            in_use,
	input  logic [pss_pkg::WEIGHT_W-1:0]    weight,
	input  pss_pkg::tok_t                   tok_in,
	output pss_pkg::tok_t                   tok_out
);
	import pss_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	credit_t credit_q;
	credit_t base;
	credit_t grown;
	credit_t debited;
	tok_t    tok_q;
	tok_t    tok_nxt;
	logic    active;
	logic    take;

	// restart clears in the same cycle the token enters cell zero
	assign base    = ctl.clear ? '0 : credit_q;
	assign grown   = sat_credit($signed({{(SAT_W-CREDIT_W){base[CREDIT_W-1]}}, base})
	                 + $signed({{(SAT_W-WEIGHT_W){1'b0}}, weight}));
	assign debited = sat_credit($signed({{(SAT_W-CREDIT_W){credit_q[CREDIT_W-1]}}, credit_q})
	                 - $signed({{(SAT_W-TOTAL_W){1'b0}}, ctl.total}));
	assign active  = tok_in.valid && in_use;
	// first cell always takes; later cells only on strictly larger credit
	assign take    = (MY_IDX == '0) || (grown > tok_in.best);

	always_comb begin
		tok_nxt = tok_in;
		if (active) begin
			tok_nxt.total = tok_in.total + TOTAL_W'(weight);
			if (take) begin
				tok_nxt.best = grown;
				tok_nxt.idx  = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (active) begin
				credit_q <= grown;
			end else if (ctl.clear) begin
				credit_q <= '0;
			end else if (ctl.debit && (ctl.winner == MY_IDX)) begin
				credit_q <= debited;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// File: design/pss_ctrl.sv
`timescale 1ns / 1ps
// Tick sequencer: injects the token, debits the winner, tracks the word position, drives results.
module pss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	pss_in_if.sink               in_ch,
	pss_out_if.source            out_ch,
	input  pss_pkg::cfg_t        cfg,
	input  pss_pkg::tok_t        tok_last,
	output pss_pkg::tok_t        tok_first,
	output pss_pkg::cell_ctl_t   cell_ctl
);
	import pss_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_HOLD} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic [SYM_W-1:0]    sym_q;
	logic [POS_W-1:0]    pos_q;
	logic                last_q;
	logic [POS_W-1:0]    word_pos_q;
	logic [IDX_W-1:0]    win_idx_q;
	logic [TOTAL_W-1:0]  win_total_q;

	logic                accept;
	logic                slot_free;
	logic                finish;
	logic                last_now;
	logic [IDX_W-1:0]    res_idx;
	logic [TOTAL_W-1:0]  res_total;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;

	assign res_idx   = (state_q == ST_SWEEP) ? tok_last.idx   : win_idx_q;
	assign res_total = (state_q == ST_SWEEP) ? tok_last.total : win_total_q;
	assign finish    = ((state_q == ST_SWEEP && tok_last.valid) || state_q == ST_HOLD)
	                   && slot_free;
	// zero length compares as one: every symbol is last
	assign last_now  = ({1'b0, word_pos_q} + (POS_W+1)'(1)) >= {1'b0, cfg.seq_len};

	always_comb begin
		tok_first       = '0;
		tok_first.valid = accept;
	end

	assign cell_ctl.clear  = (accept && in_ch.restart) || (finish && last_now);
	assign cell_ctl.debit  = finish;
	assign cell_ctl.winner = res_idx;
	assign cell_ctl.total  = res_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sym_q       <= '0;
			pos_q       <= '0;
			last_q      <= 1'b0;
			word_pos_q  <= '0;
			win_idx_q   <= '0;
			win_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.restart) begin
							word_pos_q <= '0;
						end
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (tok_last.valid) begin
						win_idx_q   <= tok_last.idx;
						win_total_q <= tok_last.total;
						state_q     <= slot_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
				sym_q       <= res_idx[SYM_W-1:0];
				pos_q       <= word_pos_q;
				last_q      <= last_now;
				word_pos_q  <= last_now ? '0 : word_pos_q + POS_W'(1);
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.symbol   = sym_q;
	assign out_ch.position = pos_q;
	assign out_ch.last     = last_q;

	a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SWEEP)
		else $error("accepted tick did not start a sweep");

	a_token_only_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.valid |-> state_q == ST_SWEEP)
		else $error("token left the chain outside a sweep");

	a_winner_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> {1'b0, res_idx} < {1'b0, cfg.n_active})
		else $error("winner is not an active symbol");

	a_word_end_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		finish && last_now |=> word_pos_q == '0)
		else $error("position not cleared at word end");

endmodule

// File: design/proportional_symbol_sequencer.sv
`timescale 1ns / 1ps
// Top level of the proportional symbol sequencer.
// Each input transaction is one tick and yields exactly one result transaction carrying
// the chosen symbol, its position in the word and a last flag. The credits sit in a chain
// of MAX_SYMBOLS cells; a token walks the chain one cell per cycle, each cell adding its
// weight and competing for the largest credit, and the controller debits the winner once
// the token has left the last cell and the result register is free. The next tick is taken
// only after that debit, so only one tick is in flight at a time; a result left waiting
// holds the block at the debit step. Configuration writes are always accepted and
// should be made only while no tick is in flight.
module proportional_symbol_sequencer #(
	parameter int unsigned MAX_SYMBOLS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	pss_in_if.sink      in_ch,
	pss_out_if.source   out_ch,
	pss_cfg_if.sink     cfg_ch
);
	import pss_pkg::*;

	cfg_t      cfg;
	cell_ctl_t cell_ctl;
	tok_t      tok_chain [MAX_SYMBOLS+1];

	pss_cfg #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
		logic                in_use;
		logic [WEIGHT_W-1:0] weight;

		if (i < NUM_WEIGHTS) begin : g_weighted
			assign in_use = cfg.n_active > NSYM_W'(i);
			assign weight = cfg.weight[i];
		end else begin : g_spare
			assign in_use = 1'b0;
			assign weight = '0;
		end

		pss_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.in_use  (in_use),
			.weight  (weight),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);
	end

	pss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg),
		.tok_last  (tok_chain[MAX_SYMBOLS]),
		.tok_first (tok_chain[0]),
		.cell_ctl  (cell_ctl)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the proportional symbol sequencer: directed cases, then random word setups.
module testbench;
	import pss_pkg::*;

	localparam int unsigned CELLS       = 4;
	localparam int unsigned SYM_LIMIT   = (CELLS < NUM_WEIGHTS) ? CELLS : NUM_WEIGHTS;
	localparam int unsigned RUN_LIMIT   = 400000;
	localparam int unsigned TAIL_CYCLES = 4 * (CELLS + 1);
	localparam int unsigned SETUPS_PER_MODE = 7;
	localparam int unsigned TICKS_PER_SETUP = 25;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [POS_W-1:0] position;
		logic             last;
	} sym_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pss_in_if  tick_if ();
	pss_out_if sym_if ();
	pss_cfg_if cfg_if ();

	proportional_symbol_sequencer #(.MAX_SYMBOLS(CELLS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (tick_if),
		.out_ch (sym_if),
		.cfg_ch (cfg_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the block: configuration and credit state after reset
	logic [POS_W-1:0]    word_len = 32'd16;
	logic [NSYM_W-1:0]   alphabet = 3'd2;
	logic [WEIGHT_W-1:0] weight_set [NUM_WEIGHTS] = '{16'd1, 16'd1, 16'd0, 16'd0};
	credit_t             credit_bal [CELLS] = '{default: '0};
	logic [POS_W-1:0]    word_pos = '0;

	sym_result_t expected_symbols [$];
	sym_result_t oldest;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	function automatic credit_t clamp_credit(input longint v);
		if (v > longint'(CREDIT_MAX)) begin
			return CREDIT_MAX;
		end else if (v < longint'(CREDIT_MIN)) begin
			return CREDIT_MIN;
		end
		return credit_t'(v);
	endfunction

	function automatic void clear_credits();
		foreach (credit_bal[c]) credit_bal[c] = '0;
		word_pos = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_SEQ_LEN: begin
				word_len = value[POS_W-1:0];
			end
			REG_SYMBOLS: begin
				alphabet = value[NSYM_W-1:0];
			end
			REG_WEIGHT0: begin
				weight_set[0] = value[WEIGHT_W-1:0];
			end
			REG_WEIGHT1: begin
				weight_set[1] = value[WEIGHT_W-1:0];
			end
			REG_WEIGHT2: begin
				weight_set[2] = value[WEIGHT_W-1:0];
			end
			REG_WEIGHT3: begin
				weight_set[3] = value[WEIGHT_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Largest-credit choice for one tick; pushes the symbol it should emit
	function automatic void next_symbol(input logic restart_bit);
		int unsigned n;
		int unsigned best;
		longint len;
		longint total;
		longint w;
		sym_result_t res;
		n = alphabet;
		if (n < 1) n = 1;
		if (n > SYM_LIMIT) n = SYM_LIMIT;
		len = (word_len == '0) ? 1 : longint'(word_len);
		if (restart_bit) clear_credits();
		total = 0;
		for (int unsigned c = 0; c < n; c++) begin
			w = longint'(weight_set[c]);
			total += w;
			credit_bal[c] = clamp_credit(longint'(credit_bal[c]) + w);
		end
		best = 0;
		for (int unsigned c = 1; c < n; c++) begin
			if (credit_bal[c] > credit_bal[best]) best = c;
		end
		credit_bal[best] = clamp_credit(longint'(credit_bal[best]) - total);
		res.symbol   = best[SYM_W-1:0];
		res.position = word_pos;
		res.last     = (longint'(word_pos) + 1) >= len;
		if (res.last) begin
			clear_credits();
		end else begin
			word_pos = word_pos + 1;
		end
		expected_symbols.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("cycle %0d: %s mismatch, got %0d, want %0d", cycles, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		sym_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && sym_if.valid && sym_if.ready) begin
			if (expected_symbols.size() == 0) begin
				report_mismatch("unexpected result, symbol", sym_if.symbol, 0);
			end else begin
				oldest = expected_symbols.pop_front();
				if (sym_if.symbol !== oldest.symbol)
					report_mismatch("symbol", sym_if.symbol, oldest.symbol);
				if (sym_if.position !== oldest.position)
					report_mismatch("position", sym_if.position, oldest.position);
				if (sym_if.last !== oldest.last)
					report_mismatch("last", sym_if.last, oldest.last);
			end
		end
	end

	// One tick; valid is left high so back-to-back transactions need no re-raise
	task automatic send_tick(input logic restart_bit);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_if.valid   <= 1'b0;
			tick_if.restart <= 1'($urandom_range(1));
			@(posedge clk);
		end
		tick_if.valid   <= 1'b1;
		tick_if.restart <= restart_bit;
		do @(posedge clk); while (!tick_if.ready);
		next_symbol(restart_bit);
	endtask

	task automatic end_burst();
		tick_if.valid <= 1'b0;
		while (expected_symbols.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.addr  <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		apply_reg(idx, value);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_power_on_word();
		repeat (3) send_tick(1'b0);
		end_burst();
	endtask

	task automatic test_zero_length();
		write_reg(REG_SEQ_LEN, '0);
		send_tick(1'b1);
		send_tick(1'b0);
		end_burst();
	endtask

	// Shorten the word below the current position: last comes at once
	task automatic test_length_lowered();
		write_reg(REG_SEQ_LEN, '1);
		repeat (3) send_tick(1'b0);
		end_burst();
		write_reg(REG_SEQ_LEN, 32'd1);
		send_tick(1'b0);
		end_burst();
	endtask

	task automatic test_alphabet_limits();
		write_reg(REG_SEQ_LEN, 32'd1000);
		write_reg(REG_SYMBOLS, 32'd0);
		send_tick(1'b0);
		send_tick(1'b0);
		end_burst();
		write_reg(REG_SYMBOLS, 32'hFFFF_FFFF);
		write_reg(REG_WEIGHT0, 32'hA5A5_FFFF);
		write_reg(REG_WEIGHT1, 32'h5A5A_0001);
		write_reg(REG_WEIGHT2, 32'hFFFF_FFFF);
		write_reg(REG_WEIGHT3, 32'h0000_8000);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		end_burst();
	endtask

	task automatic test_weights_all_zero();
		write_reg(REG_SYMBOLS, 32'd4);
		write_reg(REG_WEIGHT0, 32'hFFFF_0000);
		write_reg(REG_WEIGHT1, 32'h1234_0000);
		write_reg(REG_WEIGHT2, 32'h0000_0000);
		write_reg(REG_WEIGHT3, 32'h8000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		end_burst();
	endtask

	// Credits of symbols dropped from the alphabet must survive until it grows again
	task automatic test_idle_credits_kept();
		write_reg(REG_WEIGHT0, 32'd3);
		write_reg(REG_WEIGHT1, 32'd5);
		write_reg(REG_WEIGHT2, 32'd7);
		write_reg(REG_WEIGHT3, 32'd11);
		send_tick(1'b1);
		send_tick(1'b0);
		end_burst();
		write_reg(REG_SYMBOLS, 32'd2);
		send_tick(1'b0);
		end_burst();
		write_reg(REG_SYMBOLS, 32'd4);
		send_tick(1'b0);
		end_burst();
	endtask

	task automatic test_unmapped_index();
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		send_tick(1'b0);
		end_burst();
	endtask

	task automatic test_restart_clears();
		send_tick(1'b0);
		send_tick(1'b1);
		end_burst();
	endtask

	task automatic pick_word_setup(input int unsigned kind);
		logic [CFG_DATA_W-1:0] len;
		logic [WEIGHT_W-1:0]   w;
		case (kind)
			0: begin
				write_reg(REG_SEQ_LEN, '1);
				write_reg(REG_SYMBOLS, 32'd4);
				write_reg(REG_WEIGHT0, '1);
				write_reg(REG_WEIGHT1, '1);
				write_reg(REG_WEIGHT2, '1);
				write_reg(REG_WEIGHT3, '1);
			end
			1: begin
				write_reg(REG_SEQ_LEN, 32'd1);
				write_reg(REG_SYMBOLS, 32'd1);
				write_reg(REG_WEIGHT0, '0);
				write_reg(REG_WEIGHT1, '0);
				write_reg(REG_WEIGHT2, '0);
				write_reg(REG_WEIGHT3, '0);
			end
			default: begin
				case ($urandom_range(9))
					6: len = '0;
					7: len = $urandom;
					8: len = '1;
					9: len = $urandom_range(200, 25);
					default: len = $urandom_range(24, 1);
				endcase
				if ($urandom_range(3) != 0) write_reg(REG_SEQ_LEN, len);
				write_reg(REG_SYMBOLS, {$urandom} >> 3 << 3 | $urandom_range(7));
				for (int unsigned i = 0; i < NUM_WEIGHTS; i++) begin
					case ($urandom_range(5))
						0: w = '0;
						1: w = '1;
						2: w = WEIGHT_W'($urandom_range(8, 1));
						default: w = WEIGHT_W'($urandom);
					endcase
					if ($urandom_range(4) != 0)
						write_reg(CFG_ADDR_W'(REG_WEIGHT0 + i), {16'($urandom), w});
				end
				if ($urandom_range(7) == 0)
					write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
			end
		endcase
	endtask

	task automatic test_random_words();
		int unsigned idle_pct [4] = '{0, 47, 0, 37};
		int unsigned hold_pct [4] = '{0, 0, 47, 37};
		for (int unsigned m = 0; m < 4; m++) begin
			send_idle_pct = idle_pct[m];
			stall_pct     = hold_pct[m];
			for (int unsigned s = 0; s < SETUPS_PER_MODE; s++) begin
				pick_word_setup((s < 2) ? s : 2);
				repeat (TICKS_PER_SETUP) send_tick($urandom_range(19) == 0);
				end_burst();
			end
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	initial begin
		tick_if.valid   <= 1'b0;
		tick_if.restart <= 1'b0;
		cfg_if.valid    <= 1'b0;
		cfg_if.addr     <= REG_SEQ_LEN;
		cfg_if.data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_word();
		test_zero_length();
		test_length_lowered();
		test_alphabet_limits();
		test_weights_all_zero();
		test_idle_credits_kept();
		test_unmapped_index();
		test_restart_clears();
		test_random_words();
		end_burst();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
